>>> hdl/adsr_sawtooth_voice_unit_macros.svh
// ----------------------------------------------------------------------------
// ADSR sawtooth voice assertion macros
// Concurrent check shorthands on clk with synchronous reset rst.
// ----------------------------------------------------------------------------
`ifndef ADSR_SAWTOOTH_VOICE_UNIT_MACROS_SVH
`define ADSR_SAWTOOTH_VOICE_UNIT_MACROS_SVH

// Check that conseq holds in the same cycle as cond
`define ASV_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Check that conseq holds in the cycle after cond
`define ASV_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> hdl/asv_pkg.sv
// ----------------------------------------------------------------------------
// ADSR sawtooth voice package
// Shared step unit op codes, control struct, action codes and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package asv_pkg;

  // Operations of the shared step unit
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } asv_op_t;

  // Sequencer to step unit control
  typedef struct packed {
    asv_op_t op;
    logic    mbit;
  } asv_step_ctl_t;

  // Input action codes
  localparam logic [1:0] ACT_TICK     = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_NOTE_ON  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL    = 3'd4;

  // Register reset values
  localparam logic [15:0] ATTACK_RESET  = 16'd400;
  localparam logic [15:0] DECAY_RESET   = 16'd6000;
  localparam logic [15:0] RELEASE_RESET = 16'd6000;
  localparam logic [15:0] SUSTAIN_RESET = 16'd26214;
  localparam logic [31:0] TAIL_RESET    = 32'd4294960854;

  // Step counts of the iterative operations
  localparam logic [5:0] STEPS_16 = 6'd16;
  localparam logic [5:0] STEPS_32 = 6'd32;

endpackage

`default_nettype wire

>>> hdl/asv_step_unit.sv
// ----------------------------------------------------------------------------
// ADSR sawtooth voice step unit
// One 64-bit add/subtract datapath: plain add, plain subtract, one shift-add
// multiply step (multiplier MSB first) or one restoring divide step.
// ----------------------------------------------------------------------------
`default_nettype none

module asv_step_unit (
  input  wire logic [63:0]           acc,
  input  wire logic [63:0]           opnd,
  input  wire asv_pkg::asv_step_ctl_t ctl,
  output logic [63:0]                res
);

  logic [63:0] a_in;
  logic [63:0] b_in;
  logic        sub;
  logic [64:0] sum;

  // Select operands: multiply and divide steps shift the accumulator first
  always_comb begin
    unique case (ctl.op)
      asv_pkg::OP_ADD: begin
        a_in = acc;
        b_in = opnd;
        sub  = 1'b0;
      end
      asv_pkg::OP_SUB: begin
        a_in = acc;
        b_in = opnd;
        sub  = 1'b1;
      end
      asv_pkg::OP_MUL: begin
        a_in = {acc[62:0], 1'b0};
        b_in = ctl.mbit ? opnd : 64'd0;
        sub  = 1'b0;
      end
      asv_pkg::OP_DIV: begin
        a_in = {acc[62:0], 1'b0};
        b_in = opnd;
        sub  = 1'b1;
      end
    endcase
  end

  // Single shared adder; carry out on subtract means no borrow
  assign sum = {1'b0, a_in} + {1'b0, b_in ^ {64{sub}}} + {64'd0, sub};

  // Divide step keeps the difference and sets the quotient bit when it fits
  always_comb begin
    if (ctl.op == asv_pkg::OP_DIV) begin
      res = sum[64] ? {sum[63:1], 1'b1} : a_in;
    end else begin
      res = sum[63:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/adsr_sawtooth_voice_unit.sv
// ----------------------------------------------------------------------------
// ADSR sawtooth voice unit: one saw oscillator under a four-stage envelope.
// Ramps use 16 multiply + 16 divide steps, the sustain tail 32 multiply
// steps, the voice gain 32 multiply steps, all on one shared adder.
// One item at a time; next accept the cycle after its result is registered.
// Reset loads register defaults and clears phase, level, tick count and tail.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adsr_sawtooth_voice_unit_macros.svh"

module adsr_sawtooth_voice_unit #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned TICK_WIDTH   = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration write port
  input  wire logic                               cfg_write,
  input  wire logic [asv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [asv_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         action,
  input  wire logic [30:0]                        phase_step,
  input  wire logic [15:0]                        amplitude,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     mix_in,
  // Output channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]          mix_out,
  output logic                                    finished,
  output logic [15:0]                             envelope_level
);

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned TW  = TICK_WIDTH;
  localparam int unsigned SH  = 61 - SAMPLE_WIDTH;
  localparam logic [63:0] RND_MASK = (64'd1 << SH) - 64'd1;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_EVAL1 = 13'b0000000000010,
    ST_EVAL2 = 13'b0000000000100,
    ST_LMUL  = 13'b0000000001000,
    ST_ADDZ  = 13'b0000000010000,
    ST_SUBZ  = 13'b0000000100000,
    ST_DIV   = 13'b0000001000000,
    ST_TMUL  = 13'b0000010000000,
    ST_POST  = 13'b0000100000000,
    ST_CMUL1 = 13'b0001000000000,
    ST_CMUL2 = 13'b0010000000000,
    ST_RND   = 13'b0100000000000,
    ST_FIN   = 13'b1000000000000
  } state_t;

  // Configuration registers
  logic [15:0] attack_length;
  logic [15:0] decay_length;
  logic [15:0] release_length;
  logic [15:0] sustain_level;
  logic [31:0] tail_factor;

  // Voice state
  logic [31:0]   osc_phase, osc_phase_next;
  logic [15:0]   latched_level, latched_level_next;
  logic [TW-1:0] tick_count, tick_count_next;
  logic          gate_on, gate_on_next;
  logic [31:0]   tail_level, tail_level_next;

  // Sequencer
  state_t     state, state_next;
  logic [5:0] count, count_next;
  logic       ended, ended_next;

  // Captured item
  logic [1:0]    act_q, act_q_next;
  logic [30:0]   step_q, step_q_next;
  logic [15:0]   amp_q, amp_q_next;
  logic [SW-1:0] mix_q, mix_q_next;

  // Work registers
  logic [TW:0]   att_rem, att_rem_next;
  logic [TW:0]   rel_rem, rel_rem_next;
  logic [TW-1:0] p_val, p_val_next;
  logic [15:0]   t_lo, t_lo_next;
  logic [15:0]   kval, kval_next;
  logic [15:0]   den, den_next;
  logic [15:0]   level, level_next;
  logic [63:0]   acc, acc_next;
  logic [63:0]   opnd, opnd_next;
  logic [31:0]   mplier, mplier_next;

  // Output register
  logic          out_valid_next;
  logic [SW-1:0] mix_out_next;
  logic          finished_next;
  logic [15:0]   envelope_level_next;

  // Shared unit
  asv_pkg::asv_step_ctl_t step_ctl;
  logic [63:0]            step_res;

  // Combinational helpers
  logic [TW:0]   dmp;
  logic          att_live, rel_live, dec_live, at_edge;
  logic [31:0]   phase_mag;
  logic          phase_neg;
  logic          fin_go;
  logic [SW+3:0] mix_ext, q_ext, mix_sum;
  logic          mix_ovf;
  logic [SW-1:0] mix_sat;

  asv_step_unit u_step (
    .acc  (acc),
    .opnd (opnd),
    .ctl  (step_ctl),
    .res  (step_res)
  );

  assign in_stall = (state != ST_IDLE);
  assign fin_go   = !out_valid || !out_stall;

  // Drive the shared unit from the sequencer state
  always_comb begin
    step_ctl.mbit = mplier[31];
    if (state == ST_DIV) begin
      step_ctl.op = asv_pkg::OP_DIV;
    end else if (state == ST_SUBZ) begin
      step_ctl.op = asv_pkg::OP_SUB;
    end else if (state == ST_ADDZ || state == ST_RND) begin
      step_ctl.op = asv_pkg::OP_ADD;
    end else begin
      step_ctl.op = asv_pkg::OP_MUL;
    end
  end

  // Envelope stage decode from the registered tick differences
  assign dmp = {{(TW + 1 - 16){1'b0}}, decay_length} - {1'b0, p_val};
  assign att_live = !att_rem[TW] && (att_rem != '0);
  assign rel_live = !rel_rem[TW] && (rel_rem != '0);
  assign dec_live = !dmp[TW] && (dmp != '0);
  assign at_edge  = (dmp == '0);

  // Centered phase as sign and magnitude
  assign phase_neg = !osc_phase[31];
  assign phase_mag = osc_phase[31] ? {1'b0, osc_phase[30:0]}
                                   : (32'h8000_0000 - {1'b0, osc_phase[30:0]});

  // Add the scaled contribution to the mix and saturate
  assign mix_ext = {{4{mix_q[SW-1]}}, mix_q};
  assign q_ext   = {1'b0, acc[63:SH]};
  assign mix_sum = phase_neg ? (mix_ext - q_ext) : (mix_ext + q_ext);
  assign mix_ovf = !((&mix_sum[SW+3:SW-1]) || !(|mix_sum[SW+3:SW-1]));
  assign mix_sat = !mix_ovf ? mix_sum[SW-1:0]
                 : (mix_sum[SW+3] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

  // Sequencer and datapath next values
  always_comb begin
    state_next          = state;
    count_next          = count;
    ended_next          = ended;
    act_q_next          = act_q;
    step_q_next         = step_q;
    amp_q_next          = amp_q;
    mix_q_next          = mix_q;
    att_rem_next        = att_rem;
    rel_rem_next        = rel_rem;
    p_val_next          = p_val;
    t_lo_next           = t_lo;
    kval_next           = kval;
    den_next            = den;
    level_next          = level;
    acc_next            = acc;
    opnd_next           = opnd;
    mplier_next         = mplier;
    osc_phase_next      = osc_phase;
    latched_level_next  = latched_level;
    tick_count_next     = tick_count;
    gate_on_next        = gate_on;
    tail_level_next     = tail_level;
    out_valid_next      = out_valid && out_stall;
    mix_out_next        = mix_out;
    finished_next       = finished;
    envelope_level_next = envelope_level;

    unique case (state)
      ST_IDLE: begin
        // Take a beat
        if (in_valid) begin
          act_q_next  = action;
          step_q_next = phase_step;
          amp_q_next  = amplitude;
          mix_q_next  = mix_in;
          level_next  = 16'd0;
          ended_next  = 1'b0;
          state_next  = ST_EVAL1;
        end
      end

      ST_EVAL1: begin
        // Compare the tick count against the stage lengths, advance it; unused actions finish
        if (act_q == asv_pkg::ACT_TICK || act_q == asv_pkg::ACT_NOTE_OFF ||
            act_q == asv_pkg::ACT_NOTE_ON) begin
          att_rem_next = {{(TW + 1 - 16){1'b0}}, attack_length} - {1'b0, tick_count};
          rel_rem_next = {{(TW + 1 - 16){1'b0}}, release_length} - {1'b0, tick_count};
          p_val_next   = tick_count - {{(TW - 16){1'b0}}, attack_length};
          t_lo_next    = tick_count[15:0];
          if (tick_count != '1) begin
            tick_count_next = tick_count + {{(TW - 1){1'b0}}, 1'b1};
          end
          state_next = ST_EVAL2;
        end else begin
          state_next = ST_FIN;
        end
      end

      ST_EVAL2: begin
        // Pick the envelope stage and set up its arithmetic
        acc_next   = 64'd0;
        count_next = asv_pkg::STEPS_16;
        if (gate_on && att_live) begin
          opnd_next   = {48'd0, att_rem[15:0]};
          mplier_next = {latched_level, 16'd0};
          kval_next   = t_lo;
          den_next    = attack_length;
          state_next  = ST_LMUL;
        end else if (gate_on && dec_live) begin
          opnd_next   = {48'd0, p_val[15:0]};
          mplier_next = {sustain_level, 16'd0};
          kval_next   = dmp[15:0];
          den_next    = decay_length;
          state_next  = ST_LMUL;
        end else if (gate_on && sustain_level != 16'd0) begin
          if (at_edge) begin
            tail_level_next = {sustain_level, 16'd0};
            level_next      = sustain_level;
            state_next      = ST_POST;
          end else begin
            opnd_next   = {32'd0, tail_level};
            mplier_next = tail_factor;
            count_next  = asv_pkg::STEPS_32;
            state_next  = ST_TMUL;
          end
        end else if (!gate_on && rel_live) begin
          opnd_next   = {48'd0, rel_rem[15:0]};
          mplier_next = {latched_level, 16'd0};
          kval_next   = 16'd0;
          den_next    = release_length;
          state_next  = ST_LMUL;
        end else begin
          ended_next = 1'b1;
          state_next = ST_FIN;
        end
      end

      ST_LMUL: begin
        // Weight times level, one multiplier bit per cycle
        acc_next    = step_res;
        mplier_next = {mplier[30:0], 1'b0};
        count_next  = count - 6'd1;
        if (count == 6'd1) begin
          opnd_next  = {32'd0, kval, 16'd0};
          state_next = ST_ADDZ;
        end
      end

      ST_ADDZ: begin
        // Add k * 65535 as k << 16, then subtract k
        acc_next   = step_res;
        opnd_next  = {48'd0, kval};
        state_next = ST_SUBZ;
      end

      ST_SUBZ: begin
        // Align the numerator so the top half is the starting remainder
        acc_next   = {step_res[47:0], 16'd0};
        opnd_next  = {16'd0, den, 32'd0};
        count_next = asv_pkg::STEPS_16;
        state_next = ST_DIV;
      end

      ST_DIV: begin
        // Restoring divide, one quotient bit per cycle
        acc_next   = step_res;
        count_next = count - 6'd1;
        if (count == 6'd1) begin
          level_next = step_res[15:0];
          state_next = ST_POST;
        end
      end

      ST_TMUL: begin
        // Sustain tail times decay factor
        acc_next    = step_res;
        mplier_next = {mplier[30:0], 1'b0};
        count_next  = count - 6'd1;
        if (count == 6'd1) begin
          tail_level_next = step_res[63:32];
          level_next      = step_res[63:48];
          state_next      = ST_POST;
        end
      end

      ST_POST: begin
        // Ticks go on to the voice gain, note events finish here
        if (act_q == asv_pkg::ACT_TICK) begin
          acc_next    = 64'd0;
          opnd_next   = {32'd0, phase_mag};
          mplier_next = {amp_q, 16'd0};
          count_next  = asv_pkg::STEPS_16;
          state_next  = ST_CMUL1;
        end else begin
          state_next = ST_FIN;
        end
      end

      ST_CMUL1: begin
        // Phase magnitude times amplitude
        acc_next    = step_res;
        mplier_next = {mplier[30:0], 1'b0};
        count_next  = count - 6'd1;
        if (count == 6'd1) begin
          acc_next    = 64'd0;
          opnd_next   = step_res;
          mplier_next = {level, 16'd0};
          count_next  = asv_pkg::STEPS_16;
          state_next  = ST_CMUL2;
        end
      end

      ST_CMUL2: begin
        // Times envelope level
        acc_next    = step_res;
        mplier_next = {mplier[30:0], 1'b0};
        count_next  = count - 6'd1;
        if (count == 6'd1) begin
          opnd_next  = phase_neg ? RND_MASK : 64'd0;
          state_next = ST_RND;
        end
      end

      ST_RND: begin
        // Round negative magnitudes up so the shift floors the signed value
        acc_next   = step_res;
        state_next = ST_FIN;
      end

      ST_FIN: begin
        // Load the result once the output register is free, commit state
        if (fin_go) begin
          out_valid_next      = 1'b1;
          mix_out_next        = mix_q;
          finished_next       = ended;
          envelope_level_next = level;
          if (act_q == asv_pkg::ACT_TICK && !ended) begin
            mix_out_next   = mix_sat;
            osc_phase_next = osc_phase + {1'b0, step_q};
          end else if (act_q == asv_pkg::ACT_NOTE_OFF || act_q == asv_pkg::ACT_NOTE_ON) begin
            finished_next      = 1'b0;
            latched_level_next = level;
            gate_on_next       = (act_q == asv_pkg::ACT_NOTE_ON);
            tick_count_next    = '0;
          end
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      osc_phase     <= 32'd0;
      latched_level <= 16'd0;
      tick_count    <= '0;
      gate_on       <= 1'b1;
      tail_level    <= 32'd0;
    end else begin
      state         <= state_next;
      out_valid     <= out_valid_next;
      osc_phase     <= osc_phase_next;
      latched_level <= latched_level_next;
      tick_count    <= tick_count_next;
      gate_on       <= gate_on_next;
      tail_level    <= tail_level_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_length  <= asv_pkg::ATTACK_RESET;
      decay_length   <= asv_pkg::DECAY_RESET;
      release_length <= asv_pkg::RELEASE_RESET;
      sustain_level  <= asv_pkg::SUSTAIN_RESET;
      tail_factor    <= asv_pkg::TAIL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        asv_pkg::REG_ATTACK:  attack_length  <= cfg_data[15:0];
        asv_pkg::REG_DECAY:   decay_length   <= cfg_data[15:0];
        asv_pkg::REG_RELEASE: release_length <= cfg_data[15:0];
        asv_pkg::REG_SUSTAIN: sustain_level  <= cfg_data[15:0];
        asv_pkg::REG_TAIL:    tail_factor    <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    count          <= count_next;
    ended          <= ended_next;
    act_q          <= act_q_next;
    step_q         <= step_q_next;
    amp_q          <= amp_q_next;
    mix_q          <= mix_q_next;
    att_rem        <= att_rem_next;
    rel_rem        <= rel_rem_next;
    p_val          <= p_val_next;
    t_lo           <= t_lo_next;
    kval           <= kval_next;
    den            <= den_next;
    level          <= level_next;
    acc            <= acc_next;
    opnd           <= opnd_next;
    mplier         <= mplier_next;
    mix_out        <= mix_out_next;
    finished       <= finished_next;
    envelope_level <= envelope_level_next;
  end

  // Remainder stays below the 16-bit divisor throughout the divide
  `ASV_ASSERT_NOW(a_div_rem_bound, state == ST_DIV, acc[63:48] == 16'd0, "divide remainder overflow")

  // A finished result never carries a level
  `ASV_ASSERT_NOW(a_end_silent, out_valid && finished, envelope_level == 16'd0, "level on finished beat")

  // Leaving the final state always presents a beat
  `ASV_ASSERT_NEXT(a_fin_loads, state == ST_FIN && fin_go, out_valid, "result beat not loaded")

endmodule

`default_nettype wire
